[src/kvi_pkg.sv]
`timescale 1ns / 1ps

package kvi_pkg;

  // Field widths
  localparam int CFG_W = 7;           // key_count register
  localparam int IDX_W = 6;           // key_index field
  localparam int TW    = 24;          // key time, unsigned Q16.8
  localparam int VW    = 32;          // vector component, signed Q16.16
  localparam int NCOMP = 3;
  localparam int EW    = TW + NCOMP * VW;  // one table entry

  // Datapath widths
  localparam int SW    = TW + 1;      // signed time difference
  localparam int DW    = VW + 1;      // signed component difference
  localparam int PW    = DW + SW;     // product
  localparam int QW    = PW;          // dividend / quotient
  localparam int SUMW  = QW + 2;      // start + signed quotient

  // Divider: two quotient bits per cycle
  localparam int DIV_BITS   = 2;
  localparam int DIV_CYCLES = QW / DIV_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic key_write;
    logic query_start;
    logic search;
    logic rd_seg;
    logic rd_nxt;
    logic cap_start;
    logic diff;
    logic mul;
    logic prep;
    logic div_step;
    logic sum;
    logic out_load;
  } kvi_cmd_t;

  typedef struct packed {
    logic single;
    logic search_done;
  } kvi_stat_t;

endpackage

[src/keyframe_vector_interpolator_core.sv]
`timescale 1ns / 1ps

// Load item: written to the key table in the accept cycle, one item per cycle while idle,
//   no result. Query item: out_valid rises after the search, table reads, multiply,
//   divide and sum; the segment walk reads one entry per cycle, the divider retires 2 bits
//   per cycle. One query at a time; the next item is taken while the result waits.
// Reset (rst, synchronous): controller idle, no result pending, key_count = 1.
//   The key table is not cleared; entries hold garbage until loaded.
module keyframe_vector_interpolator_core #(
  parameter int MAX_KEYS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: key_count
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kvi_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [kvi_pkg::IDX_W-1:0]       key_index,
  input  logic [kvi_pkg::TW-1:0]          key_time,
  input  logic signed [kvi_pkg::VW-1:0]   key_x,
  input  logic signed [kvi_pkg::VW-1:0]   key_y,
  input  logic signed [kvi_pkg::VW-1:0]   key_z,
  input  logic [kvi_pkg::TW-1:0]          query_time,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [kvi_pkg::VW-1:0]   out_x,
  output logic signed [kvi_pkg::VW-1:0]   out_y,
  output logic signed [kvi_pkg::VW-1:0]   out_z,
  output logic                            saturated
);

  kvi_pkg::kvi_cmd_t  cmd;
  kvi_pkg::kvi_stat_t stat;

  // register write never stalls; the user must change config only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer: key writes, search, table reads, multiply, divide, sum, output handoff
  kvi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // key table, search pointer, three component lanes, result register
  kvi_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .key_index  (key_index),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .query_time (query_time),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .saturated  (saturated)
  );

  // a query item occupies the block: nothing accepted the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == kvi_pkg::FUNC_QUERY) |=> !in_ready)
    else $error("input accepted right after a query item");

  // load items never produce a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == kvi_pkg::FUNC_LOAD && !out_valid) |=> !out_valid)
    else $error("result appeared after a load item");

  // a saturated result has at least one component at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
       out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
       out_z == 32'sh7fffffff || out_z == 32'sh80000000))
    else $error("saturated flag without a clamped component");

endmodule

[src/kvi_ram.sv]
`timescale 1ns / 1ps

module kvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/kvi_lane.sv]
`timescale 1ns / 1ps

// One vector component: difference, product, rounded divide, saturating sum.
module kvi_lane (
  input  logic                              clk,
  input  kvi_pkg::kvi_cmd_t                 cmd,
  input  logic signed [kvi_pkg::VW-1:0]     rd_comp,
  input  logic signed [kvi_pkg::SW-1:0]     dq,
  input  logic [kvi_pkg::TW-1:0]            adt,
  input  logic                              dt_neg,
  input  logic                              zero,
  output logic signed [kvi_pkg::VW-1:0]     res,
  output logic                              sat
);

  logic signed [kvi_pkg::VW-1:0]   s;
  logic signed [kvi_pkg::DW-1:0]   d;
  logic signed [kvi_pkg::PW-1:0]   prod;
  logic                            neg;
  logic [kvi_pkg::QW-1:0]          div_q;
  logic [kvi_pkg::TW-1:0]          rem;

  logic [kvi_pkg::QW-1:0]          div_q_next;
  logic [kvi_pkg::TW-1:0]          rem_next;
  logic [kvi_pkg::QW-1:0]          mag;
  logic [kvi_pkg::SUMW-1:0]        qx;
  logic [kvi_pkg::SUMW-1:0]        sum;
  logic                            ovf_pos;
  logic                            ovf_neg;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [kvi_pkg::TW:0]   sh;
    logic [kvi_pkg::TW-1:0] r;
    logic [kvi_pkg::QW-1:0] qv;
    r  = rem;
    qv = div_q;
    for (int k = 0; k < kvi_pkg::DIV_BITS; k++) begin
      sh = {r, qv[kvi_pkg::QW-1]};
      qv = {qv[kvi_pkg::QW-2:0], 1'b0};
      if (sh >= {1'b0, adt}) begin
        r     = kvi_pkg::TW'(sh - {1'b0, adt});
        qv[0] = 1'b1;
      end else begin
        r = sh[kvi_pkg::TW-1:0];
      end
    end
    rem_next   = r;
    div_q_next = qv;
  end

  // |prod| + |dt|/2, one adder with carry in
  assign mag = (prod[kvi_pkg::PW-1] ? ~kvi_pkg::QW'(prod) : kvi_pkg::QW'(prod))
             + kvi_pkg::QW'(adt >> 1) + kvi_pkg::QW'(prod[kvi_pkg::PW-1]);

  assign qx  = {2'b00, div_q};
  assign sum = kvi_pkg::SUMW'(s) + (neg ? ~qx : qx) + kvi_pkg::SUMW'(neg);

  assign ovf_pos = !sum[kvi_pkg::SUMW-1] && (sum[kvi_pkg::SUMW-2:kvi_pkg::VW-1] != '0);
  assign ovf_neg =  sum[kvi_pkg::SUMW-1] && (sum[kvi_pkg::SUMW-2:kvi_pkg::VW-1] != '1);

  always_ff @(posedge clk) begin
    if (cmd.cap_start) begin
      s <= rd_comp;
    end
    if (cmd.diff) begin
      d <= kvi_pkg::DW'(rd_comp) - kvi_pkg::DW'(s);
    end
    if (cmd.mul) begin
      prod <= d * dq;
    end
    if (cmd.prep) begin
      neg   <= prod[kvi_pkg::PW-1] ^ dt_neg;
      div_q <= mag;
      rem   <= '0;
    end
    if (cmd.div_step) begin
      div_q <= div_q_next;
      rem   <= rem_next;
    end
    if (cmd.sum) begin
      priority if (zero) begin
        res <= s;
        sat <= 1'b0;
      end else if (ovf_pos) begin
        res <= {1'b0, {(kvi_pkg::VW-1){1'b1}}};
        sat <= 1'b1;
      end else if (ovf_neg) begin
        res <= {1'b1, {(kvi_pkg::VW-1){1'b0}}};
        sat <= 1'b1;
      end else begin
        res <= $signed(sum[kvi_pkg::VW-1:0]);
        sat <= 1'b0;
      end
    end
  end

endmodule

[src/kvi_dpath.sv]
`timescale 1ns / 1ps

module kvi_dpath #(
  parameter int MAX_KEYS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kvi_pkg::kvi_cmd_t               cmd,
  output kvi_pkg::kvi_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [kvi_pkg::CFG_W-1:0]       cfg_data,
  input  logic [kvi_pkg::IDX_W-1:0]       key_index,
  input  logic [kvi_pkg::TW-1:0]          key_time,
  input  logic signed [kvi_pkg::VW-1:0]   key_x,
  input  logic signed [kvi_pkg::VW-1:0]   key_y,
  input  logic signed [kvi_pkg::VW-1:0]   key_z,
  input  logic [kvi_pkg::TW-1:0]          query_time,
  output logic signed [kvi_pkg::VW-1:0]   out_x,
  output logic signed [kvi_pkg::VW-1:0]   out_y,
  output logic signed [kvi_pkg::VW-1:0]   out_z,
  output logic                            saturated
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int KW = (NW > kvi_pkg::CFG_W) ? NW : kvi_pkg::CFG_W;

  logic [kvi_pkg::CFG_W-1:0] key_count;
  logic [KW-1:0]             kc_ext;
  logic [NW-1:0]             n_eff;

  logic                      we;
  logic [AW-1:0]             raddr;
  logic [kvi_pkg::EW-1:0]    rdata;
  logic [kvi_pkg::TW-1:0]    rd_time;

  logic [kvi_pkg::TW-1:0]    q_reg;
  logic                      single;
  logic [NW-1:0]             ptr;
  logic                      chk_valid;
  logic [AW-1:0]             chk_addr;
  logic                      found;
  logic [AW-1:0]             seg;
  logic                      issue;

  logic [kvi_pkg::TW-1:0]          t0;
  logic signed [kvi_pkg::SW-1:0]   dq;
  logic signed [kvi_pkg::SW-1:0]   dt;
  logic [kvi_pkg::TW-1:0]          adt;
  logic                            dt_neg;
  logic                            zero;

  logic signed [kvi_pkg::VW-1:0]   lane_res [kvi_pkg::NCOMP];
  logic [kvi_pkg::NCOMP-1:0]       lane_sat;

  // key count register, zero reads as one, clamped to table size
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvi_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  assign kc_ext = KW'(key_count);
  assign n_eff  = (kc_ext == '0)              ? NW'(1) :
                  (kc_ext > KW'(MAX_KEYS))   ? NW'(MAX_KEYS) : NW'(kc_ext);

  // key table: {time, x, y, z}
  assign we = cmd.key_write && ({26'd0, key_index} < 32'(MAX_KEYS));

  always_comb begin
    priority if (cmd.rd_seg) begin
      raddr = seg;
    end else if (cmd.rd_nxt) begin
      raddr = seg + AW'(1);
    end else begin
      raddr = AW'(ptr);
    end
  end

  kvi_ram #(
    .WIDTH (kvi_pkg::EW),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(key_index)),
    .wdata ({key_time, key_x, key_y, key_z}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time = rdata[kvi_pkg::EW-1 -: kvi_pkg::TW];

  // segment search: one read issued per cycle until found, compare in the cycle after the read
  assign issue = (ptr < n_eff) && !found;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_reg     <= query_time;
      single    <= (n_eff == NW'(1));
      ptr       <= NW'(1);
      chk_valid <= 1'b0;
      found     <= 1'b0;
      seg       <= '0;
    end else if (cmd.search) begin
      chk_valid <= issue;
      if (issue) begin
        ptr      <= ptr + NW'(1);
        chk_addr <= AW'(ptr);
      end
      if (chk_valid && !found && (q_reg < rd_time)) begin
        found <= 1'b1;
        seg   <= chk_addr - AW'(1);
      end
    end
  end

  assign stat.single      = (n_eff == NW'(1));
  assign stat.search_done = found || (!chk_valid && (ptr >= n_eff));

  // shared time terms
  always_ff @(posedge clk) begin
    if (cmd.cap_start) begin
      t0 <= rd_time;
    end
    if (cmd.diff) begin
      dq <= $signed({1'b0, q_reg}) - $signed({1'b0, t0});
      dt <= $signed({1'b0, rd_time}) - $signed({1'b0, t0});
    end
    if (cmd.mul) begin
      adt    <= dt[kvi_pkg::SW-1] ? kvi_pkg::TW'(-dt) : kvi_pkg::TW'(dt);
      dt_neg <= dt[kvi_pkg::SW-1];
      zero   <= (dt == '0) || single;
    end
  end

  for (genvar c = 0; c < kvi_pkg::NCOMP; c++) begin : g_lane
    kvi_lane u_lane (
      .clk     (clk),
      .cmd     (cmd),
      .rd_comp ($signed(rdata[kvi_pkg::VW*(kvi_pkg::NCOMP-1-c) +: kvi_pkg::VW])),
      .dq      (dq),
      .adt     (adt),
      .dt_neg  (dt_neg),
      .zero    (zero),
      .res     (lane_res[c]),
      .sat     (lane_sat[c])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x     <= lane_res[0];
      out_y     <= lane_res[1];
      out_z     <= lane_res[2];
      saturated <= |lane_sat;
    end
  end

endmodule

[src/kvi_ctrl.sv]
`timescale 1ns / 1ps

module kvi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  output logic               out_valid,
  input  logic               out_ready,
  output kvi_pkg::kvi_cmd_t  cmd,
  input  kvi_pkg::kvi_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SEARCH = 10'b00_0000_0010,
    S_RD_SEG = 10'b00_0000_0100,
    S_RD_NXT = 10'b00_0000_1000,
    S_DIFF   = 10'b00_0001_0000,
    S_MUL    = 10'b00_0010_0000,
    S_PREP   = 10'b00_0100_0000,
    S_DIV    = 10'b00_1000_0000,
    S_SUM    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [kvi_pkg::CNT_W-1:0] cnt;
  logic                      out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == kvi_pkg::FUNC_LOAD) begin
            cmd.key_write = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_next      = stat.single ? S_RD_SEG : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          state_next = S_RD_SEG;
        end
      end
      S_RD_SEG: begin
        cmd.rd_seg = 1'b1;
        state_next = S_RD_NXT;
      end
      S_RD_NXT: begin
        cmd.rd_nxt    = 1'b1;
        cmd.cap_start = 1'b1;
        state_next    = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == kvi_pkg::CNT_W'(kvi_pkg::DIV_CYCLES - 1)) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.prep) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + kvi_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
